>>> design/multilevel_feedback_queue_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multilevel feedback queue scheduler
// Shared property forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH
`define MULTILEVEL_FEEDBACK_QUEUE_SCHEDULER_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define MFQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mfq assertion failed");

// Next-cycle implication, ignored while reset is high.
`define MFQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mfq assertion failed");

// Next-cycle implication that is checked during reset too.
`define MFQ_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("mfq assertion failed");

`endif

>>> design/mfq_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Field widths, codes and the item type shared by the scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfq_pkg;

   localparam int OP_W       = 3;
   localparam int PID_W      = 15;
   localparam int CPU_W      = 16;
   localparam int TIME_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int NQ_W       = 4;
   localparam int TS_W       = 16;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   localparam int DEF_MAX_PROCS  = 64;
   localparam int DEF_MAX_QUEUES = 8;
   localparam int FRONT_DEPTH    = 2;

   localparam logic [NQ_W-1:0] RESET_NUM_QUEUES = NQ_W'(2);
   localparam logic [TS_W-1:0] RESET_TIMESLICE  = TS_W'(100);

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_QUEUES = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_TIMESLICE  = CSR_IDX_W'(1);

   typedef enum logic [OP_W-1:0] {
      OP_NEW       = 3'd0,
      OP_DISPATCH  = 3'd1,
      OP_READY     = 3'd2,
      OP_WAIT      = 3'd3,
      OP_TERMINATE = 3'd4
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_RANGE   = 2'd1,
      STAT_QUEUED  = 2'd2,
      STAT_NO_BASE = 2'd3
   } status_type;

   // One classified request as it travels from the front to the back.
   typedef struct packed {
      logic                  known;
      opcode_type            op;
      logic [PID_W-1:0]      pid;
      logic [CPU_W-1:0]      cpu;
      logic [TIME_W-1:0]     now;
   } item_type;

   // Flow control from the back to the front.
   typedef struct packed {
      logic take;
      logic clearing;
   } back_ctrl_type;

endpackage

`default_nettype wire

>>> design/mfq_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write and registered read.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

>>> design/mfq_front.sv
// ----------------------------------------------------------------------------
// Scheduler front end
// Accepts request beats, classifies the opcode and buffers them for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic [mfq_pkg::OP_W-1:0]   req_opcode,
   input  wire logic [mfq_pkg::PID_W-1:0]  req_pid,
   input  wire logic [mfq_pkg::CPU_W-1:0]  req_cpu_time_used,
   input  wire logic [mfq_pkg::TIME_W-1:0] req_now_ms,
   output logic                            out_valid,
   output mfq_pkg::item_type               out_item,
   input  wire mfq_pkg::back_ctrl_type     back_ctrl
);
   import mfq_pkg::*;

   localparam int PW = $clog2(FRONT_DEPTH);
   localparam int CW = $clog2(FRONT_DEPTH + 1);

   item_type        entry_ff [FRONT_DEPTH];
   logic [PW-1:0]   wptr_ff, wptr_in;
   logic [PW-1:0]   rptr_ff, rptr_in;
   logic [CW-1:0]   count_ff, count_in;
   item_type        cls;
   logic            do_push, do_pop;

   // Classify the opcode; codes past terminate are marked unknown.
   always_comb begin
      cls.known = 1'b1;
      cls.op    = OP_NEW;
      cls.pid   = req_pid;
      cls.cpu   = req_cpu_time_used;
      cls.now   = req_now_ms;
      case (req_opcode)
         OP_NEW:       cls.op = OP_NEW;
         OP_DISPATCH:  cls.op = OP_DISPATCH;
         OP_READY:     cls.op = OP_READY;
         OP_WAIT:      cls.op = OP_WAIT;
         OP_TERMINATE: cls.op = OP_TERMINATE;
         default:      cls.known = 1'b0;
      endcase
   end

   // Queue control.
   assign req_full  = (count_ff == CW'(FRONT_DEPTH)) || back_ctrl.clearing;
   assign do_push   = req_push && !req_full;
   assign out_valid = (count_ff != '0);
   assign do_pop    = out_valid && back_ctrl.take;
   assign out_item  = entry_ff[rptr_ff];

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == PW'(FRONT_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == PW'(FRONT_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wptr_ff] <= cls;
      end
   end

endmodule

`default_nettype wire

>>> design/mfq_back.sv
// ----------------------------------------------------------------------------
// Scheduler back end
// Reads the slot tables, executes the opcode, updates the queues and holds
// the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module mfq_back #(
   parameter int MAX_PROCS  = mfq_pkg::DEF_MAX_PROCS,
   parameter int MAX_QUEUES = mfq_pkg::DEF_MAX_QUEUES
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire mfq_pkg::item_type            in_item,
   output mfq_pkg::back_ctrl_type            back_ctrl,
   input  wire logic [mfq_pkg::NQ_W-1:0]     num_queues,
   input  wire logic [mfq_pkg::TS_W-1:0]     timeslice,
   output logic                              rsp_valid,
   input  wire logic                         rsp_pop,
   output logic [mfq_pkg::PID_W-1:0]         rsp_dispatched_pid,
   output logic [mfq_pkg::TIME_W-1:0]        rsp_wait_ms,
   output logic                              rsp_io_return,
   output logic [mfq_pkg::STATUS_W-1:0]      rsp_status
);
   import mfq_pkg::*;

   localparam int SW  = $clog2(MAX_PROCS);
   localparam int QW  = $clog2(MAX_QUEUES);
   localparam int LVW = $clog2(MAX_QUEUES + 1);
   localparam int IW  = QW + TIME_W;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   // Flag word: finished, io pending, queued.
   typedef struct packed {
      logic fin;
      logic io;
      logic queued;
   } flags_type;

   state_type            state_ff;
   logic [SW-1:0]        clr_ff;
   logic [PID_W-1:0]     base_ff;
   logic                 base_valid_ff;
   logic [SW-1:0]        head_ff [MAX_QUEUES];
   logic [SW-1:0]        tail_ff [MAX_QUEUES];
   logic [MAX_QUEUES-1:0] ne_ff;

   item_type             item_ff;
   logic [SW-1:0]        slot_ff;
   status_type           stat_ff;
   logic [QW-1:0]        sel_q_ff;
   logic [SW-1:0]        sel_s_ff;
   logic                 sel_last_ff;
   logic                 found_ff;
   logic                 spliced_ff;

   logic                 rsp_valid_ff;
   logic [PID_W-1:0]     rsp_pid_ff;
   logic [TIME_W-1:0]    rsp_wait_ff;
   logic                 rsp_io_ff;
   status_type           rsp_stat_ff;

   // Level count clamped into the legal range.
   logic [NQ_W:0]        nq_ext;
   logic [LVW-1:0]       lv;
   logic [QW-1:0]        lv_max_q;
   logic [QW-1:0]        new_prio;

   always_comb begin
      nq_ext = {1'b0, num_queues};
      if (nq_ext < (NQ_W+1)'(2)) begin
         lv = LVW'(2);
      end else if (nq_ext > (NQ_W+1)'(MAX_QUEUES)) begin
         lv = LVW'(MAX_QUEUES);
      end else begin
         lv = LVW'(nq_ext);
      end
      lv_max_q = QW'(lv - 1'b1);
      new_prio = (lv == LVW'(2)) ? '0 : QW'(lv >> 1);
   end

   // Slot lookup for the incoming request.
   logic [PID_W-1:0]     base_eff;
   logic                 bv_eff;
   logic [PID_W:0]       diff;
   logic                 in_range;
   logic [SW-1:0]        slot;
   status_type           stat_new;

   always_comb begin
      base_eff = base_ff;
      bv_eff   = base_valid_ff;
      if (in_item.known && in_item.op == OP_NEW && !base_valid_ff) begin
         base_eff = in_item.pid;
         bv_eff   = 1'b1;
      end
      diff     = {1'b0, in_item.pid} - {1'b0, base_eff};
      in_range = !diff[PID_W] && (diff < (PID_W+1)'(MAX_PROCS));
      slot     = diff[SW-1:0];
      stat_new = STAT_OK;
      if (in_item.known && in_item.op != OP_DISPATCH) begin
         if (!bv_eff) begin
            stat_new = STAT_NO_BASE;
         end else if (!in_range) begin
            stat_new = STAT_RANGE;
         end
      end
   end

   // Dispatch pick, with the two-level splice folded in.
   logic                  splice;
   logic [MAX_QUEUES-1:0] ne_eff;
   logic [QW-1:0]         pick_q;
   logic                  pick_found;
   logic [SW-1:0]         pick_s;
   logic [SW-1:0]         pick_tail;

   always_comb begin
      splice = (lv == LVW'(2)) && !ne_ff[0] && ne_ff[1];
      ne_eff = ne_ff;
      if (splice) begin
         ne_eff[0] = 1'b1;
         ne_eff[1] = 1'b0;
      end
      pick_q     = '0;
      pick_found = 1'b0;
      for (int q = MAX_QUEUES - 1; q >= 0; q--) begin
         if (ne_eff[q] && (LVW'(q) < lv)) begin
            pick_q     = QW'(q);
            pick_found = 1'b1;
         end
      end
      pick_s    = splice ? head_ff[1] : head_ff[pick_q];
      pick_tail = splice ? tail_ff[1] : tail_ff[pick_q];
   end

   // Slot tables.
   logic              flag_we, info_we, next_we;
   logic [SW-1:0]     flag_waddr, info_waddr, next_waddr, raddr;
   flags_type         flag_wdata, flag_rd;
   logic [IW-1:0]     info_wdata, info_rd;
   logic [SW-1:0]     next_wdata, next_rd;
   logic [QW-1:0]     rd_prio;
   logic [TIME_W-1:0] rd_time;

   // The read address stays on the captured slot while the execute step
   // waits, so the read data holds through a stall.
   assign raddr   = (state_ff == S_EXEC) ?
                    ((item_ff.op == OP_DISPATCH) ? sel_s_ff : slot_ff) :
                    ((in_item.op == OP_DISPATCH) ? pick_s : slot);
   assign rd_prio = info_rd[IW-1:TIME_W];
   assign rd_time = info_rd[TIME_W-1:0];

   mfq_ram #(.WIDTH(3), .DEPTH(MAX_PROCS)) u_flag_ram (
      .clock (clock),
      .we    (flag_we),
      .waddr (flag_waddr),
      .wdata (flag_wdata),
      .raddr (raddr),
      .rdata (flag_rd)
   );

   mfq_ram #(.WIDTH(IW), .DEPTH(MAX_PROCS)) u_info_ram (
      .clock (clock),
      .we    (info_we),
      .waddr (info_waddr),
      .wdata (info_wdata),
      .raddr (raddr),
      .rdata (info_rd)
   );

   mfq_ram #(.WIDTH(SW), .DEPTH(MAX_PROCS)) u_next_ram (
      .clock (clock),
      .we    (next_we),
      .waddr (next_waddr),
      .wdata (next_wdata),
      .raddr (raddr),
      .rdata (next_rd)
   );

   // Execute step: results, table writes and queue updates.
   logic                  exec_go;
   logic [QW-1:0]         push_prio;
   logic [QW-1:0]         push_q;
   logic                  do_push;
   logic [SW-1:0]         head_in [MAX_QUEUES];
   logic [SW-1:0]         tail_in [MAX_QUEUES];
   logic [MAX_QUEUES-1:0] ne_in;
   logic [PID_W-1:0]      res_pid;
   logic [TIME_W-1:0]     res_wait;
   logic                  res_io;
   status_type            res_stat;

   assign exec_go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_pop);

   always_comb begin
      flag_we    = 1'b0;
      flag_waddr = slot_ff;
      flag_wdata = flag_rd;
      info_we    = 1'b0;
      info_waddr = slot_ff;
      info_wdata = info_rd;
      next_we    = 1'b0;
      next_waddr = '0;
      next_wdata = slot_ff;
      head_in    = head_ff;
      tail_in    = tail_ff;
      ne_in      = ne_ff;
      res_pid    = '0;
      res_wait   = '0;
      res_io     = 1'b0;
      res_stat   = stat_ff;
      do_push    = 1'b0;
      push_prio  = new_prio;

      // Demotion on ready when the time slice is used up.
      if (item_ff.op == OP_READY) begin
         push_prio = rd_prio;
         if (item_ff.cpu >= timeslice && rd_prio < lv_max_q) begin
            push_prio = rd_prio + 1'b1;
         end
      end
      push_q = (push_prio > lv_max_q) ? lv_max_q : push_prio;

      if (state_ff == S_CLEAR) begin
         flag_we    = 1'b1;
         flag_waddr = clr_ff;
         flag_wdata = '0;
      end else if (exec_go && item_ff.known) begin
         case (item_ff.op)
            OP_DISPATCH: begin
               if (spliced_ff) begin
                  ne_in[0]   = 1'b1;
                  ne_in[1]   = 1'b0;
                  tail_in[0] = tail_ff[1];
               end
               if (found_ff) begin
                  if (sel_last_ff) begin
                     ne_in[sel_q_ff] = 1'b0;
                  end else begin
                     head_in[sel_q_ff] = next_rd;
                  end
                  res_pid           = base_ff + PID_W'(sel_s_ff);
                  res_wait          = item_ff.now - rd_time;
                  res_io            = flag_rd.io;
                  flag_we           = 1'b1;
                  flag_waddr        = sel_s_ff;
                  flag_wdata.io     = 1'b0;
                  flag_wdata.queued = 1'b0;
               end
            end
            OP_NEW, OP_READY: begin
               if (stat_ff == STAT_OK) begin
                  if (flag_rd.queued) begin
                     res_stat = STAT_QUEUED;
                  end else begin
                     do_push = 1'b1;
                  end
               end
            end
            OP_WAIT: begin
               if (stat_ff == STAT_OK) begin
                  flag_we       = 1'b1;
                  flag_wdata.io = 1'b1;
                  info_we       = 1'b1;
                  if (rd_prio != '0) begin
                     info_wdata[IW-1:TIME_W] = rd_prio - 1'b1;
                  end
               end
            end
            OP_TERMINATE: begin
               if (stat_ff == STAT_OK) begin
                  flag_we        = 1'b1;
                  flag_wdata.fin = 1'b1;
               end
            end
            default: begin
               res_stat = STAT_OK;
            end
         endcase

         // Enqueue at the tail of the chosen level.
         if (do_push) begin
            flag_we           = 1'b1;
            flag_wdata.queued = 1'b1;
            if (item_ff.op == OP_NEW) begin
               flag_wdata.io  = 1'b0;
               flag_wdata.fin = 1'b0;
            end
            info_we    = 1'b1;
            info_wdata = {push_q, item_ff.now};
            if (ne_ff[push_q]) begin
               next_we    = 1'b1;
               next_waddr = tail_ff[push_q];
            end else begin
               head_in[push_q] = slot_ff;
               ne_in[push_q]   = 1'b1;
            end
            tail_in[push_q] = slot_ff;
         end
      end
   end

   // Sequencer and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         base_ff       <= '0;
         base_valid_ff <= 1'b0;
         ne_ff         <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (exec_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_pop) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SW'(MAX_PROCS - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (in_valid) begin
                  base_ff       <= base_eff;
                  base_valid_ff <= bv_eff;
                  state_ff      <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (exec_go) begin
                  ne_ff    <= ne_in;
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && in_valid) begin
         item_ff     <= in_item;
         slot_ff     <= slot;
         stat_ff     <= stat_new;
         sel_q_ff    <= pick_q;
         sel_s_ff    <= pick_s;
         sel_last_ff <= (pick_tail == pick_s);
         found_ff    <= pick_found;
         spliced_ff  <= splice;
      end
      if (exec_go) begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         rsp_pid_ff  <= res_pid;
         rsp_wait_ff <= res_wait;
         rsp_io_ff   <= res_io;
         rsp_stat_ff <= res_stat;
      end
   end

   assign back_ctrl.take     = (state_ff == S_IDLE);
   assign back_ctrl.clearing = (state_ff == S_CLEAR);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_dispatched_pid = rsp_pid_ff;
   assign rsp_wait_ms        = rsp_wait_ff;
   assign rsp_io_return      = rsp_io_ff;
   assign rsp_status         = rsp_stat_ff;

endmodule

`default_nettype wire

>>> design/multilevel_feedback_queue_scheduler.sv
// ----------------------------------------------------------------------------
// Multilevel feedback queue scheduler
// Top level: configuration registers, front end buffer and back end engine.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake            Contents
//  req_*     in         push / full          opcode, pid, cpu time, time now
//  rsp_*     out        empty / pop          pid, wait time, io return, status
//  csr_*     in         valid / ready        register index, write data
//
//  In the back end each request first reads the slot tables (registered
//  RAM read) and then executes and writes back.
//  After reset a clearing pass over all MAX_PROCS slots zeroes the flags;
//  full stays high during it, while configuration writes are taken.
//  A result beat waiting on pop holds the back end; the front buffer of
//  two beats keeps accepting meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module multilevel_feedback_queue_scheduler #(
   parameter int MAX_PROCS  = mfq_pkg::DEF_MAX_PROCS,
   parameter int MAX_QUEUES = mfq_pkg::DEF_MAX_QUEUES
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   output logic                                req_full,
   input  wire logic [mfq_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [mfq_pkg::PID_W-1:0]      req_pid,
   input  wire logic [mfq_pkg::CPU_W-1:0]      req_cpu_time_used,
   input  wire logic [mfq_pkg::TIME_W-1:0]     req_now_ms,
   output logic                                rsp_empty,
   input  wire logic                           rsp_pop,
   output logic [mfq_pkg::PID_W-1:0]           rsp_dispatched_pid,
   output logic [mfq_pkg::TIME_W-1:0]          rsp_wait_ms,
   output logic                                rsp_io_return,
   output logic [mfq_pkg::STATUS_W-1:0]        rsp_status,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mfq_pkg::CSR_DATA_W-1:0] csr_data
);
   import mfq_pkg::*;

   logic [NQ_W-1:0] num_queues_ff;
   logic [TS_W-1:0] timeslice_ff;
   logic            item_valid;
   item_type        item;
   back_ctrl_type   back_ctrl;
   logic            rsp_valid;

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_queues_ff <= RESET_NUM_QUEUES;
         timeslice_ff  <= RESET_TIMESLICE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_NUM_QUEUES: num_queues_ff <= csr_data[NQ_W-1:0];
            CSR_TIMESLICE:  timeslice_ff  <= csr_data[TS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   mfq_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_opcode        (req_opcode),
      .req_pid           (req_pid),
      .req_cpu_time_used (req_cpu_time_used),
      .req_now_ms        (req_now_ms),
      .out_valid         (item_valid),
      .out_item          (item),
      .back_ctrl         (back_ctrl)
   );

   mfq_back #(
      .MAX_PROCS  (MAX_PROCS),
      .MAX_QUEUES (MAX_QUEUES)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (item_valid),
      .in_item            (item),
      .back_ctrl          (back_ctrl),
      .num_queues         (num_queues_ff),
      .timeslice          (timeslice_ff),
      .rsp_valid          (rsp_valid),
      .rsp_pop            (rsp_pop),
      .rsp_dispatched_pid (rsp_dispatched_pid),
      .rsp_wait_ms        (rsp_wait_ms),
      .rsp_io_return      (rsp_io_return),
      .rsp_status         (rsp_status)
   );

   assign rsp_empty = !rsp_valid;

endmodule

`default_nettype wire

>>> design/mfq_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Watches the top level ports and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multilevel_feedback_queue_scheduler_macros.svh"

module mfq_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_push,
   input  wire logic                           req_full,
   input  wire logic [mfq_pkg::OP_W-1:0]       req_opcode,
   input  wire logic [mfq_pkg::PID_W-1:0]      req_pid,
   input  wire logic [mfq_pkg::CPU_W-1:0]      req_cpu_time_used,
   input  wire logic [mfq_pkg::TIME_W-1:0]     req_now_ms,
   input  wire logic                           rsp_empty,
   input  wire logic                           rsp_pop,
   input  wire logic [mfq_pkg::PID_W-1:0]      rsp_dispatched_pid,
   input  wire logic [mfq_pkg::TIME_W-1:0]     rsp_wait_ms,
   input  wire logic                           rsp_io_return,
   input  wire logic [mfq_pkg::STATUS_W-1:0]   rsp_status,
   input  wire logic                           csr_valid,
   input  wire logic                           csr_ready,
   input  wire logic [mfq_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mfq_pkg::CSR_DATA_W-1:0] csr_data
);
   import mfq_pkg::*;

   // Reset leaves no result beat behind, and the clearing pass blocks input.
   `MFQ_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, rsp_empty && req_full)

   // A waiting result beat holds until it is popped.
   `MFQ_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_dispatched_pid) && $stable(rsp_wait_ms) && $stable(rsp_io_return) && $stable(rsp_status))

   // An error status comes with no dispatch fields.
   `MFQ_ASSERT_IMPLY(a_err_fields, clock, reset, !rsp_empty && rsp_status != STAT_OK, rsp_dispatched_pid == '0 && rsp_wait_ms == '0 && !rsp_io_return)

   // A beat popped as soon as it appears, with no request accepted, cannot be replaced in the next cycle.
   `MFQ_ASSERT_NEXT(a_no_early_rsp, clock, reset, !rsp_empty && rsp_pop && !(req_push && !req_full) && $past(rsp_empty), rsp_empty)

endmodule

bind multilevel_feedback_queue_scheduler mfq_checker u_mfq_checker (.*);

`default_nettype wire

>>> test/multilevel_feedback_queue_scheduler_checker.sv
// ----------------------------------------------------------------------------
// Scheduler checker
// Watches the request, response and register channels. Every accepted request
// beat is run through a local model of the scheduler, and every accepted
// response beat is compared field by field with the oldest predicted outcome.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multilevel_feedback_queue_scheduler_checker
   import mfq_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic [OP_W-1:0]       req_opcode,
   input  logic [PID_W-1:0]      req_pid,
   input  logic [CPU_W-1:0]      req_cpu_time_used,
   input  logic [TIME_W-1:0]     req_now_ms,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [PID_W-1:0]      rsp_dispatched_pid,
   input  logic [TIME_W-1:0]     rsp_wait_ms,
   input  logic                  rsp_io_return,
   input  logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int                    outstanding,
   output int                    failures
);

   localparam int SLOTS  = DEF_MAX_PROCS;
   localparam int LEVELS = DEF_MAX_QUEUES;

   typedef struct packed {
      logic [PID_W-1:0]  pid;
      logic [TIME_W-1:0] wait_ms;
      logic              io_return;
      status_type        status;
   } outcome_type;

   // Local copy of the configuration and of the scheduler tables.
   logic [NQ_W-1:0]   num_queues;
   logic [TS_W-1:0]   timeslice;
   logic [PID_W-1:0]  base_pid;
   logic              base_valid;
   logic [2:0]        priority_tab [SLOTS];
   logic              io_pending   [SLOTS];
   logic              finished     [SLOTS];
   logic              queued       [SLOTS];
   logic [TIME_W-1:0] enqueued_at  [SLOTS];
   logic [5:0]        link         [SLOTS];
   logic [5:0]        head         [LEVELS];
   logic [5:0]        tail         [LEVELS];
   logic [LEVELS-1:0] nonempty;

   outcome_type due_outcomes [$];

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: %s got %0h, predicted %0h", $realtime, what, got, want);
      failures++;
   endtask

   function automatic int active_levels();
      int n;
      n = num_queues;
      if (n < 2) n = 2;
      if (n > LEVELS) n = LEVELS;
      return n;
   endfunction

   // Append a slot to the tail of its priority level, clamping the level.
   task automatic enqueue_slot(input int slot, input logic [TIME_W-1:0] now);
      int lv;
      int q;
      lv = active_levels();
      q = priority_tab[slot];
      if (q > lv - 1) q = lv - 1;
      priority_tab[slot] = 3'(q);
      enqueued_at[slot] = now;
      queued[slot] = 1'b1;
      if (nonempty[q]) link[tail[q]] = 6'(slot);
      else begin
         head[q] = 6'(slot);
         nonempty[q] = 1'b1;
      end
      tail[q] = 6'(slot);
   endtask

   // Predict the outcome of one request beat and update the tables.
   task automatic schedule_event(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                                 input logic [CPU_W-1:0] cpu,
                                 input logic [TIME_W-1:0] now);
      outcome_type o;
      int lv;
      int slot;
      int s;
      bit done;
      o = '0;
      lv = active_levels();
      slot = 0;
      done = 0;
      if (op == OP_DISPATCH) begin
         // With two levels an empty level 0 takes over the whole of level 1.
         if (lv == 2 && !nonempty[0] && nonempty[1]) begin
            head[0] = head[1];
            tail[0] = tail[1];
            nonempty[1:0] = 2'b01;
         end
         for (int q = 0; q < lv; q++) begin
            if (!done && nonempty[q]) begin
               s = head[q];
               if (tail[q] == 6'(s)) nonempty[q] = 1'b0;
               else head[q] = link[s];
               queued[s] = 1'b0;
               o.pid = PID_W'(base_pid + PID_W'(s));
               o.wait_ms = now - enqueued_at[s];
               o.io_return = io_pending[s];
               io_pending[s] = 1'b0;
               done = 1;
            end
         end
      end else if (op <= OP_TERMINATE) begin
         if (op == OP_NEW && !base_valid) begin
            base_pid = pid;
            base_valid = 1'b1;
         end
         if (!base_valid) o.status = STAT_NO_BASE;
         else if (pid < base_pid || 32'(pid - base_pid) >= SLOTS) o.status = STAT_RANGE;
         else slot = pid - base_pid;
         if (o.status == STAT_OK) begin
            if ((op == OP_NEW || op == OP_READY) && queued[slot]) begin
               o.status = STAT_QUEUED;
            end else if (op == OP_NEW) begin
               priority_tab[slot] = (lv == 2) ? 3'd0 : 3'(lv / 2);
               io_pending[slot] = 1'b0;
               finished[slot] = 1'b0;
               enqueue_slot(slot, now);
            end else if (op == OP_READY) begin
               if (cpu >= timeslice && priority_tab[slot] + 1 <= lv - 1)
                  priority_tab[slot] = priority_tab[slot] + 3'd1;
               enqueue_slot(slot, now);
            end else if (op == OP_WAIT) begin
               io_pending[slot] = 1'b1;
               if (priority_tab[slot] > 0) priority_tab[slot] = priority_tab[slot] - 3'd1;
            end else begin
               finished[slot] = 1'b1;
            end
         end
      end
      due_outcomes.push_back(o);
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         num_queues = RESET_NUM_QUEUES;
         timeslice = RESET_TIMESLICE;
         base_pid = '0;
         base_valid = 1'b0;
         nonempty = '0;
         for (int i = 0; i < SLOTS; i++) begin
            priority_tab[i] = '0;
            io_pending[i] = 1'b0;
            finished[i] = 1'b0;
            queued[i] = 1'b0;
            enqueued_at[i] = '0;
            link[i] = '0;
         end
         for (int i = 0; i < LEVELS; i++) begin
            head[i] = '0;
            tail[i] = '0;
         end
         due_outcomes.delete();
      end else begin
         // Register writes.
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_NUM_QUEUES) num_queues = csr_data[NQ_W-1:0];
            else if (csr_index == CSR_TIMESLICE) timeslice = csr_data[TS_W-1:0];
         end
         // Response beats against the oldest prediction.
         if (rsp_pop && !rsp_empty) begin
            if (due_outcomes.size() == 0) begin
               report_mismatch("response beat with nothing predicted, pid", 32'(rsp_dispatched_pid),
                               32'hx);
            end else begin
               want = due_outcomes.pop_front();
               if (rsp_dispatched_pid !== want.pid)
                  report_mismatch("dispatched_pid", 32'(rsp_dispatched_pid), 32'(want.pid));
               if (rsp_wait_ms !== want.wait_ms)
                  report_mismatch("wait_ms", rsp_wait_ms, want.wait_ms);
               if (rsp_io_return !== want.io_return)
                  report_mismatch("io_return", 32'(rsp_io_return), 32'(want.io_return));
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
            end
         end
         // Request beats.
         if (req_push && !req_full)
            schedule_event(req_opcode, req_pid, req_cpu_time_used, req_now_ms);
      end
      outstanding = due_outcomes.size();
   end

endmodule

>>> test/multilevel_feedback_queue_scheduler_tb.sv
// ----------------------------------------------------------------------------
// Scheduler testbench
// Drives directed and random scheduler requests with random gaps, pops the
// responses with random stalls, steps through several register settings and
// reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module multilevel_feedback_queue_scheduler_tb;
   import mfq_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int PHASE_ITEMS    = 200;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_push = 1'b0;
   logic                  req_full;
   logic [OP_W-1:0]       req_opcode = '0;
   logic [PID_W-1:0]      req_pid = '0;
   logic [CPU_W-1:0]      req_cpu_time_used = '0;
   logic [TIME_W-1:0]     req_now_ms = '0;
   logic                  rsp_empty;
   logic                  rsp_pop = 1'b0;
   logic [PID_W-1:0]      rsp_dispatched_pid;
   logic [TIME_W-1:0]     rsp_wait_ms;
   logic                  rsp_io_return;
   logic [STATUS_W-1:0]   rsp_status;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;
   int                    outstanding;
   int                    failures;
   int                    idle_cycles = 0;

   // Slots that a new has written, so that ready and wait never read a blank.
   bit                    slot_written [DEF_MAX_PROCS];
   logic [TIME_W-1:0]     clock_ms = 32'd1000;

   multilevel_feedback_queue_scheduler u_top (.*);

   multilevel_feedback_queue_scheduler_checker u_checker (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // Watchdog on cycles with no beat on any channel.
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Response side: a random stall, possibly none, before every beat.
   initial begin
      int stall;
      forever begin
         stall = $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (reset || rsp_empty);
      end
   end

   // One request beat after a random gap; push stays high when the gap is zero.
   task automatic send_request(input logic [OP_W-1:0] op, input logic [PID_W-1:0] pid,
                               input logic [CPU_W-1:0] cpu, input logic [TIME_W-1:0] now);
      int gap;
      gap = $urandom_range(0, 16);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_opcode <= op;
      req_pid <= pid;
      req_cpu_time_used <= cpu;
      req_now_ms <= now;
      if (op == OP_NEW && pid < DEF_MAX_PROCS) slot_written[pid] = 1;
      do @(posedge clock); while (req_full);
   endtask

   // Wait until every predicted response is in and the engine has settled.
   // It first lets the checker see the last request beat.
   task automatic drain_responses();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // A pid of a slot that a new has already written.
   function automatic logic [PID_W-1:0] written_pid();
      int s;
      do s = $urandom_range(0, DEF_MAX_PROCS - 1); while (!slot_written[s]);
      return PID_W'(s);
   endfunction

   // Mostly well-formed traffic over the table, with some noise mixed in.
   task automatic send_random_request();
      int pick;
      logic [CPU_W-1:0] cpu;
      logic [TIME_W-1:0] now;
      pick = $urandom_range(0, 99);
      clock_ms = clock_ms + $urandom_range(0, 500);
      now = ($urandom_range(0, 19) == 0) ? $urandom : clock_ms;
      cpu = ($urandom_range(0, 1) == 0) ? CPU_W'($urandom) : CPU_W'($urandom_range(0, 600));
      if (pick < 20)
         send_request(OP_NEW, PID_W'($urandom_range(0, DEF_MAX_PROCS - 1)), cpu, now);
      else if (pick < 45)
         send_request(OP_DISPATCH, PID_W'($urandom), cpu, now);
      else if (pick < 65)
         send_request(OP_READY, written_pid(), cpu, now);
      else if (pick < 78)
         send_request(OP_WAIT, written_pid(), cpu, now);
      else if (pick < 86)
         send_request(OP_TERMINATE, PID_W'($urandom_range(0, DEF_MAX_PROCS - 1)), cpu, now);
      else if (pick < 94)
         send_request(OP_W'($urandom_range(0, 4)),
                      PID_W'($urandom_range(DEF_MAX_PROCS, 32767)), cpu, now);
      else
         send_request(OP_W'($urandom_range(5, 7)), PID_W'($urandom), cpu, $urandom);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] level_set [6];
      logic [CSR_DATA_W-1:0] slice_set [6];
      level_set = '{16'd2, 16'd8, 16'd3, 16'd15, 16'd0, 16'd6};
      slice_set = '{16'd1, 16'd65535, 16'd100, 16'd0, 16'd7, 16'd500};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: before any new, unused opcodes, empty dispatch.
      send_request(OP_READY, 15'd5, 16'd0, 32'd10);
      send_request(OP_WAIT, 15'd5, 16'd0, 32'd11);
      send_request(OP_TERMINATE, 15'h7fff, 16'hffff, 32'hffffffff);
      send_request(3'd5, 15'h7fff, 16'hffff, 32'hffffffff);
      send_request(3'd6, 15'd1, 16'd1, 32'd1);
      send_request(3'd7, 15'd0, 16'd0, 32'd0);
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd20);
      // The first new fixes the base at pid zero.
      send_request(OP_NEW, 15'd0, 16'd0, 32'd1000);
      send_request(OP_NEW, 15'd0, 16'd0, 32'd1001);
      send_request(OP_NEW, 15'd63, 16'd0, 32'hfffffff0);
      send_request(OP_NEW, 15'd64, 16'd0, 32'd1002);
      send_request(OP_READY, 15'h7fff, 16'd0, 32'd1003);
      send_request(OP_READY, 15'd63, 16'd0, 32'd1004);
      // Pid zero is dispatched, then a wait time that wraps.
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd1500);
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd5);
      // Wait then a long ready demotes into level 1, which is spliced back.
      send_request(OP_WAIT, 15'd0, 16'd0, 32'd2000);
      send_request(OP_READY, 15'd0, 16'hffff, 32'd2001);
      send_request(OP_NEW, 15'd1, 16'd0, 32'd2002);
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd2100);
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd2200);
      send_request(OP_TERMINATE, 15'd1, 16'd0, 32'd2300);
      send_request(OP_READY, 15'd1, 16'd99, 32'd2301);
      send_request(OP_DISPATCH, 15'd0, 16'd0, 32'd2400);

      // Random phases, each under its own register setting.
      for (int p = 0; p < 6; p++) begin
         drain_responses();
         write_register(CSR_NUM_QUEUES, level_set[p]);
         write_register(CSR_TIMESLICE, slice_set[p]);
         for (int i = 0; i < PHASE_ITEMS; i++) send_random_request();
      end

      drain_responses();
      if (failures == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/mfq_pkg.sv
design/mfq_ram.sv
design/mfq_front.sv
design/mfq_back.sv
design/multilevel_feedback_queue_scheduler.sv
design/mfq_checker.sv
test/multilevel_feedback_queue_scheduler_checker.sv
test/multilevel_feedback_queue_scheduler_tb.sv
